[hw/rtl/gfd_pkg.sv]
`default_nettype none

package gfd_pkg;

    localparam int WORD_W             = 32;
    localparam int FRAC_W             = 31;
    localparam int PROD_W             = 2 * WORD_W;
    localparam int SHIFT_W            = 5;
    localparam int DEF_ITERATIONS     = 5;
    localparam int DEF_DIVISOR_WIDTH  = 8;

    localparam logic [PROD_W-1:0]  ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [SHIFT_W-1:0] NORM_TOP   = SHIFT_W'(FRAC_W - 1);

    // control that travels alongside the datapath words
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [SHIFT_W-1:0] shift;
    } t_ctl;

endpackage

`default_nettype wire

[hw/rtl/goldschmidt_fixed_divider_unit.sv]
// goldschmidt_fixed_divider_unit: unsigned Q1.31 numerator divided by a small integer divisor
// command channel: a transaction is taken on a clock edge with i_start high and o_busy low;
//   i_numerator and i_divisor are sampled on that edge
// result channel: o_strobe is high for one cycle with o_quotient valid in that cycle;
//   the receiver cannot hold results off and none is needed
// throughput: one transaction per cycle outside reset, set by the fully pipelined datapath:
//   one normalise stage, a multiply stage and a round stage per iteration, one shift stage
// o_busy is low except while i_rst_n is low, so commands are only refused during reset
// reset is synchronous and clears every valid bit, so no strobe follows from earlier work
// a zero divisor gives a quotient of zero; the scaled numerator wraps modulo 2^32 if it reaches two
`default_nettype none

module goldschmidt_fixed_divider_unit
    import gfd_pkg::*;
#(
    parameter int ITERATIONS    = DEF_ITERATIONS,
    parameter int DIVISOR_WIDTH = DEF_DIVISOR_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [WORD_W-1:0]        i_numerator,
    input  wire logic [DIVISOR_WIDTH-1:0] i_divisor,
    output logic                          o_strobe,
    output logic      [WORD_W-1:0]        o_quotient
);

    t_ctl              ctl [ITERATIONS+1];
    logic [WORD_W-1:0] d   [ITERATIONS+1];
    logic [WORD_W-1:0] n   [ITERATIONS+1];

    assign o_busy = ~i_rst_n;

    gfd_norm #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH)
    ) u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start & ~o_busy),
        .i_numerator (i_numerator),
        .i_divisor   (i_divisor),
        .o_ctl       (ctl[0]),
        .o_d         (d[0]),
        .o_n         (n[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        gfd_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .i_d     (d[k]),
            .i_n     (n[k]),
            .o_ctl   (ctl[k+1]),
            .o_d     (d[k+1]),
            .o_n     (n[k+1])
        );
    end

    gfd_denorm u_denorm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl[ITERATIONS]),
        .i_n        (n[ITERATIONS]),
        .o_strobe   (o_strobe),
        .o_quotient (o_quotient)
    );

endmodule

`default_nettype wire

[hw/rtl/gfd_norm.sv]
`default_nettype none

module gfd_norm
    import gfd_pkg::*;
#(
    parameter int DIVISOR_WIDTH = DEF_DIVISOR_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [WORD_W-1:0]        i_numerator,
    input  wire logic [DIVISOR_WIDTH-1:0] i_divisor,
    output t_ctl                          o_ctl,
    output logic      [WORD_W-1:0]        o_d,
    output logic      [WORD_W-1:0]        o_n
);

    logic [SHIFT_W-1:0] lead;
    t_ctl               n_ctl;
    t_ctl               r_ctl;
    logic [WORD_W-1:0]  n_d;
    logic [WORD_W-1:0]  r_d;
    logic [WORD_W-1:0]  r_n;

    // leading-one index
    always_comb begin
        lead = '0;
        for (int i = 0; i < DIVISOR_WIDTH; i++) begin
            if (i_divisor[i]) begin
                lead = SHIFT_W'(i);
            end
        end
    end

    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.zero  = (i_divisor == '0);
        n_ctl.shift = lead + SHIFT_W'(1);
        n_d         = WORD_W'(i_divisor) << (NORM_TOP - lead);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        r_n <= i_numerator;
    end

    assign o_ctl = r_ctl;
    assign o_d   = r_d;
    assign o_n   = r_n;

endmodule

`default_nettype wire

[hw/rtl/gfd_iter.sv]
`default_nettype none

module gfd_iter
    import gfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [WORD_W-1:0] i_d,
    input  wire logic [WORD_W-1:0] i_n,
    output t_ctl                   o_ctl,
    output logic      [WORD_W-1:0] o_d,
    output logic      [WORD_W-1:0] o_n
);

    logic [WORD_W-1:0] factor;
    logic [PROD_W-1:0] n_pd;
    logic [PROD_W-1:0] n_pn;
    logic [PROD_W-1:0] r_pd;
    logic [PROD_W-1:0] r_pn;
    t_ctl              r_ctl_mul;
    logic [PROD_W-1:0] sum_d;
    logic [PROD_W-1:0] sum_n;
    t_ctl              r_ctl_rnd;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] r_n;

    // multiply by two minus d
    always_comb begin
        factor = WORD_W'(0) - i_d;
        n_pd   = PROD_W'(i_d) * PROD_W'(factor);
        n_pn   = PROD_W'(i_n) * PROD_W'(factor);
    end

    // round half up and keep one word
    always_comb begin
        sum_d = r_pd + ROUND_BIAS;
        sum_n = r_pn + ROUND_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_mul <= '0;
            r_ctl_rnd <= '0;
        end else begin
            r_ctl_mul <= i_ctl;
            r_ctl_rnd <= r_ctl_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pd <= n_pd;
        r_pn <= n_pn;
        r_d  <= sum_d[FRAC_W+WORD_W-1:FRAC_W];
        r_n  <= sum_n[FRAC_W+WORD_W-1:FRAC_W];
    end

    assign o_ctl = r_ctl_rnd;
    assign o_d   = r_d;
    assign o_n   = r_n;

endmodule

`default_nettype wire

[hw/rtl/gfd_denorm.sv]
`default_nettype none

module gfd_denorm
    import gfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [WORD_W-1:0] i_n,
    output logic                   o_strobe,
    output logic      [WORD_W-1:0] o_quotient
);

    logic [WORD_W-1:0] n_quotient;
    logic              r_strobe;
    logic [WORD_W-1:0] r_quotient;

    always_comb begin
        n_quotient = i_ctl.zero ? '0 : (i_n >> i_ctl.shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
    end

    assign o_strobe   = r_strobe;
    assign o_quotient = r_quotient;

endmodule

`default_nettype wire
